// ===== rtl/bsm_pkg.sv =====
`timescale 1ns / 1ps
package bsm_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned RadW   = 31;
  localparam int unsigned DiffW  = 33;
  localparam int unsigned SqW    = 67;
  localparam int unsigned DistW  = 34;
  localparam int unsigned ProdW  = DiffW + DistW;
  localparam int unsigned TolW   = 32;
  localparam int unsigned MinW   = 16;
  localparam int unsigned CntW   = 7;

  localparam logic [TolW-1:0] TolReset = 32'd429497;
  localparam logic [MinW-1:0] MinReset = 16'd1;

  localparam logic [0:0] CfgTol = 1'b0;
  localparam logic [0:0] CfgMin = 1'b1;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic [RadW-1:0]          radius;
    logic                     restart;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] merged_x;
    logic signed [CoordW-1:0] merged_y;
    logic signed [CoordW-1:0] merged_z;
    logic [RadW-1:0]          merged_radius;
    logic                     saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_TEST,
    ST_SQRT,
    ST_RAD,
    ST_MUL,
    ST_DIV,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic sq_step;
    logic test;
    logic sqrt_init;
    logic sqrt_step;
    logic rad;
    logic mul;
    logic div_init;
    logic div_step;
    logic axis_commit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic take_in;
    logic sqrt_last;
    logic div_last;
    logic axis_last;
    logic move;
  } sts_t;

endpackage

// ===== rtl/bsm_ctrl.sv =====
`timescale 1ns / 1ps
module bsm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  bsm_pkg::sts_t  sts,
  output bsm_pkg::cmd_t  cmd
);

  bsm_pkg::state_t state_r, state_nxt;
  logic [1:0] sqc_r, sqc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsm_pkg::ST_IDLE;
      sqc_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      sqc_r   <= sqc_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sqc_nxt   = sqc_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      bsm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          sqc_nxt  = 2'd0;
          state_nxt = sts.take_in ? bsm_pkg::ST_DONE : bsm_pkg::ST_SQ;
        end
      end
      bsm_pkg::ST_SQ: begin
        cmd.sq_step = 1'b1;
        sqc_nxt = sqc_r + 2'd1;
        if (sqc_r == 2'd2) state_nxt = bsm_pkg::ST_TEST;
      end
      bsm_pkg::ST_TEST: begin
        cmd.test = 1'b1;
        cmd.sqrt_init = 1'b1;
        state_nxt = sts.take_in ? bsm_pkg::ST_DONE : bsm_pkg::ST_SQRT;
      end
      bsm_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) state_nxt = bsm_pkg::ST_RAD;
      end
      bsm_pkg::ST_RAD: begin
        cmd.rad = 1'b1;
        state_nxt = sts.move ? bsm_pkg::ST_MUL : bsm_pkg::ST_DONE;
      end
      bsm_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        cmd.div_init = 1'b1;
        state_nxt = bsm_pkg::ST_DIV;
      end
      bsm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = bsm_pkg::ST_NEXT;
      end
      bsm_pkg::ST_NEXT: begin
        cmd.axis_commit = 1'b1;
        state_nxt = sts.axis_last ? bsm_pkg::ST_DONE : bsm_pkg::ST_MUL;
      end
      bsm_pkg::ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.finish = 1'b1;
          state_nxt = bsm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bsm_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/bsm_dp.sv =====
`timescale 1ns / 1ps
module bsm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bsm_pkg::in_item_t             in_data,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [bsm_pkg::TolW-1:0]      cfg_wdata,
  input  bsm_pkg::cmd_t                 cmd,
  output bsm_pkg::sts_t                 sts,
  output bsm_pkg::out_item_t            out_data
);

  localparam int unsigned CW = bsm_pkg::CoordW;
  localparam int unsigned RW = bsm_pkg::RadW;
  localparam int unsigned DW = bsm_pkg::DiffW;
  localparam int unsigned SW = bsm_pkg::SqW;
  localparam int unsigned QW = bsm_pkg::DistW;
  localparam int unsigned PW = bsm_pkg::ProdW;
  localparam int unsigned NW = bsm_pkg::CntW;

  logic [bsm_pkg::TolW-1:0] tol_r;
  logic [bsm_pkg::MinW-1:0] minmv_r;
  logic signed [CW-1:0] hx_r, hy_r, hz_r;
  logic [RW-1:0] hr_r;
  logic sat_r;

  logic signed [CW-1:0] ix_r, iy_r, iz_r;
  logic [RW-1:0] ir_r;
  logic signed [DW-1:0] d_r [3];
  logic [1:0] sqi_r;
  logic [SW-1:0] sq_r;
  logic take_r;

  logic [QW-1:0] root_r;
  logic [SW+1:0] rem_r;
  logic [SW-1:0] rad_sh_r;
  logic [NW-1:0] it_r;

  logic [QW-1:0] dist_r;
  logic [QW-1:0] grow_r;
  logic move_r;
  logic [1:0] ax_r;
  logic [PW-1:0] num_r;
  logic [QW:0] drem_r;
  logic [PW-1:0] quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= bsm_pkg::TolReset;
      minmv_r <= bsm_pkg::MinReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bsm_pkg::CfgTol: tol_r   <= cfg_wdata;
        bsm_pkg::CfgMin: minmv_r <= cfg_wdata[bsm_pkg::MinW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [DW-1:0] cur_d;
  logic [DW-1:0] cur_a;
  logic [2*DW-1:0] cur_sq;
  logic [RW-1:0] rdiff;
  logic [2*RW-1:0] rd2;
  logic [SW-1:0] lhs;
  logic nested;
  logic [SW+1:0] trial;
  logic [QW+1:0] nr_full;
  logic [QW-1:0] nr_raw;
  logic [DW-1:0] mag;
  logic [QW:0] dshift;
  logic signed [CW:0] hsel;
  logic signed [CW:0] moved;

  always_comb begin
    cur_d = d_r[sqi_r];
    cur_a = cur_d[DW-1] ? DW'(-cur_d) : DW'(cur_d);
    cur_sq = cur_a * cur_a;
    rdiff = (hr_r > ir_r) ? hr_r - ir_r : ir_r - hr_r;
    rd2 = rdiff * rdiff;
    lhs = SW'(rd2) + SW'(tol_r);
    nested = (sq_r <= lhs);
    trial = rem_r - {root_r, 2'b01};
    nr_full = (QW+2)'(root_r) + (QW+2)'(ir_r) + (QW+2)'(hr_r);
    nr_raw = nr_full[QW:1];
    mag = d_r[ax_r][DW-1] ? DW'(-d_r[ax_r]) : DW'(d_r[ax_r]);
    dshift = {drem_r[QW-1:0], num_r[PW-1]};
    hsel = (ax_r == 2'd0) ? (CW+1)'(hx_r) : (ax_r == 2'd1) ? (CW+1)'(hy_r) : (CW+1)'(hz_r);
    moved = d_r[ax_r][DW-1] ? hsel - (CW+1)'(quo_r) : hsel + (CW+1)'(quo_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ix_r <= in_data.center_x;
      iy_r <= in_data.center_y;
      iz_r <= in_data.center_z;
      ir_r <= in_data.radius;
      d_r[0] <= DW'(in_data.center_x) - DW'(hx_r);
      d_r[1] <= DW'(in_data.center_y) - DW'(hy_r);
      d_r[2] <= DW'(in_data.center_z) - DW'(hz_r);
      sqi_r <= 2'd0;
      sq_r <= '0;
    end
    if (cmd.sq_step) begin
      sq_r  <= sq_r + SW'(cur_sq);
      sqi_r <= sqi_r + 2'd1;
    end
    if (cmd.sqrt_init) begin
      root_r <= '0;
      rem_r <= '0;
      rad_sh_r <= {sq_r[SW-2:0], 1'b0};
      it_r <= '0;
    end
    if (cmd.sqrt_step) begin
      rad_sh_r <= {rad_sh_r[SW-3:0], 2'b00};
      it_r <= it_r + NW'(1);
      if (!trial[SW+1]) begin
        rem_r <= {trial[SW-1:0], rad_sh_r[SW-1:SW-2]};
        root_r <= {root_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[SW-1:0], rad_sh_r[SW-1:SW-2]};
        root_r <= {root_r[QW-2:0], 1'b0};
      end
    end
    if (cmd.rad) begin
      dist_r <= root_r;
      ax_r <= 2'd0;
    end
    if (cmd.mul) begin
      num_r <= mag * grow_r;
      drem_r <= '0;
      quo_r <= '0;
      it_r <= '0;
    end
    if (cmd.div_step) begin
      num_r <= {num_r[PW-2:0], 1'b0};
      it_r <= it_r + NW'(1);
      if (dshift >= (QW+1)'(dist_r)) begin
        drem_r <= dshift - (QW+1)'(dist_r);
        quo_r <= {quo_r[PW-2:0], 1'b1};
      end else begin
        drem_r <= dshift;
        quo_r <= {quo_r[PW-2:0], 1'b0};
      end
    end
    if (cmd.axis_commit) ax_r <= ax_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hx_r <= '0;
      hy_r <= '0;
      hz_r <= '0;
      hr_r <= '0;
      sat_r <= 1'b0;
      take_r <= 1'b0;
      move_r <= 1'b0;
      grow_r <= '0;
    end else begin
      if (cmd.load) begin
        sat_r <= 1'b0;
        take_r <= 1'b0;
        if (in_data.restart || hr_r == '0) begin
          hx_r <= in_data.center_x;
          hy_r <= in_data.center_y;
          hz_r <= in_data.center_z;
          hr_r <= in_data.radius;
        end
      end
      if (cmd.test) begin
        take_r <= nested;
        if (nested && hr_r < ir_r) begin
          hx_r <= ix_r;
          hy_r <= iy_r;
          hz_r <= iz_r;
          hr_r <= ir_r;
        end
      end
      if (cmd.rad) begin
        grow_r <= nr_raw - QW'(hr_r);
        move_r <= root_r > QW'(minmv_r);
        if (nr_raw > QW'({RW{1'b1}})) begin
          sat_r <= 1'b1;
        end
      end
      if (cmd.axis_commit) begin
        unique case (ax_r)
          2'd0: hx_r <= moved[CW-1:0];
          2'd1: hy_r <= moved[CW-1:0];
          default: hz_r <= moved[CW-1:0];
        endcase
        if (ax_r == 2'd2) begin
          hr_r <= sat_r ? {RW{1'b1}} : nr_raw[RW-1:0];
        end
      end
      if (cmd.rad && !(root_r > QW'(minmv_r))) begin
        hr_r <= (nr_raw > QW'({RW{1'b1}})) ? {RW{1'b1}} : nr_raw[RW-1:0];
      end
    end
  end

  always_comb begin
    sts.take_in   = cmd.load ? (in_data.restart || hr_r == '0) : take_r | nested;
    sts.sqrt_last = (it_r == NW'(QW - 1));
    sts.div_last  = (it_r == NW'(PW - 1));
    sts.axis_last = (ax_r == 2'd2);
    sts.move      = root_r > QW'(minmv_r);
    out_data.merged_x = hx_r;
    out_data.merged_y = hy_r;
    out_data.merged_z = hz_r;
    out_data.merged_radius = hr_r;
    out_data.saturated = sat_r;
  end

endmodule

// ===== rtl/bounding_sphere_merge.sv =====
`timescale 1ns / 1ps
// Running bounding sphere over Q16.16 spheres, one result per transfer. An item
// that restarts or meets an empty sphere goes from the load straight to its
// result; a nested one first passes the three squaring steps and the
// containment test. A true merge adds the bit-serial square root, which is all
// it adds when the center stays, and a pass of the shared bit-serial divider
// per axis when the center moves. One item is in flight at a time; the next is
// taken after the result transfer, so a stalled result holds the input.
module bounding_sphere_merge (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  bsm_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output bsm_pkg::out_item_t       out_data,
  input  logic                     cfg_we,
  input  logic                     cfg_addr,
  input  logic [bsm_pkg::TolW-1:0] cfg_wdata
);

  bsm_pkg::cmd_t cmd;
  bsm_pkg::sts_t sts;

  bsm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .cmd(cmd)
  );

  bsm_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .sts(sts), .out_data(out_data)
  );

endmodule
